// ===== sv/bmpd_pkg.sv =====
package bmpd_pkg;

  // Parse phases of one file.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_PALETTE = 3'd1,
    PH_SKIP    = 3'd2,
    PH_PIXELS  = 3'd3,
    PH_PAD     = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  // Error codes reported in a result item.
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_PLANES = 3'd1,
    ERR_DEPTH  = 3'd2,
    ERR_COMP   = 3'd3,
    ERR_OFFSET = 3'd4,
    ERR_DIM    = 3'd5
  } err_e;

  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned PAL_IDX_W = 8;
  localparam int unsigned PAL_CNT_W = PAL_IDX_W + 2;
  localparam int unsigned COORD_W   = 16;

  // Byte positions at which a little-endian header field is complete.
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_PLANES_END = 32'd27;
  localparam logic [31:0] POS_DEPTH_END  = 32'd29;
  localparam logic [31:0] POS_COMP_END   = 32'd33;
  localparam logic [31:0] POS_COUNT_END  = 32'd49;
  localparam logic [31:0] POS_HDR_END    = 32'd53;

  // Wide enough for the header size plus four bytes per entry of any 32-bit count.
  localparam logic [34:0] HDR_BYTES     = 35'd54;
  localparam logic [31:0] DEFAULT_COUNT = 32'd256;
  localparam logic [15:0] REQ_PLANES    = 16'd1;
  localparam logic [15:0] REQ_BPP       = 16'd8;

  // Metadata of one result item, before the palette color is attached.
  typedef struct packed {
    logic                is_error;
    err_e                code;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic                last;
  } res_t;

  // Palette access request from the parser for the current byte.
  typedef struct packed {
    logic                 clear;
    logic                 wr_en;
    logic                 ld_en;
    logic [PAL_IDX_W-1:0] wr_idx;
    logic [23:0]          wr_rgb;
    logic                 rd_en;
    logic [PAL_IDX_W-1:0] rd_idx;
  } pal_req_t;

endpackage

// ===== sv/bmpd_ifs.sv =====
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       start_of_file;

  modport source (output valid, file_byte, start_of_file, input ready);
  modport sink   (input valid, file_byte, start_of_file, output ready);
endinterface

interface bmpd_out_if;
  logic        valid;
  logic        ready;
  logic        is_error;
  logic [2:0]  error_code;
  logic [15:0] pixel_row;
  logic [15:0] pixel_col;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;

  modport source (output valid, is_error, error_code, pixel_row, pixel_col, red, green, blue,
                  last_pixel, input ready);
  modport sink   (input valid, is_error, error_code, pixel_row, pixel_col, red, green, blue,
                  last_pixel, output ready);
endinterface

// ===== sv/bmp_8bit_palette_decoder_unit.sv =====
// Channel   Dir  Modport  Payload
// byte_i    in   sink     file_byte[7:0], start_of_file
// pix_o     out  source   is_error, error_code[2:0], pixel_row[15:0], pixel_col[15:0],
//                         red[7:0], green[7:0], blue[7:0], last_pixel
//
// One byte per cycle while ready; an item passes the lookup stage and output register.
// The single palette memory read port limits lookups to one per cycle when not stalled.
// Reset is asynchronous and active low; all palette entries read as black until loaded.
// The lookup stage and the output register hold up to two items. byte_i.ready follows
// pix_o.ready in the same cycle once both hold an item, so in steady flow any sink stall
// stops the input at once; with the lookup stage empty one more byte still gets in.
module bmp_8bit_palette_decoder_unit #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bmpd_in_if.sink          byte_i,
  bmpd_out_if.source       pix_o
);
  import bmpd_pkg::*;

  logic        accept;
  logic        res_valid;
  res_t        res;
  pal_req_t    pal_req;
  logic [23:0] pal_rdata;
  logic        pal_loaded;
  logic        in_ready;
  logic        out_valid;
  res_t        out_res;
  logic [23:0] out_rgb;

  // A byte is taken whenever the result pipeline has room for one more item.
  assign accept       = byte_i.valid & in_ready;
  assign byte_i.ready = in_ready;

  // The parser walks the header, palette, skip, pixel and pad phases one byte at a
  // time and raises palette writes or lookups for the byte it takes.
  bmpd_parse #(
    .DIM_BITS (DIM_BITS)
  ) u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .file_byte_i     (byte_i.file_byte),
    .start_of_file_i (byte_i.start_of_file),
    .res_valid_o     (res_valid),
    .res_o           (res),
    .pal_o           (pal_req)
  );

  // The palette memory answers a pixel lookup from a registered read port.
  bmpd_pal u_pal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (pal_req),
    .rdata_o  (pal_rdata),
    .loaded_o (pal_loaded)
  );

  // The output side joins the color to its coordinates and buffers the item.
  bmpd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .rdata_i     (pal_rdata),
    .loaded_i    (pal_loaded),
    .out_ready_i (pix_o.ready),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_res_o   (out_res),
    .out_rgb_o   (out_rgb)
  );

  assign pix_o.valid      = out_valid;
  assign pix_o.is_error   = out_res.is_error;
  assign pix_o.error_code = out_res.code;
  assign pix_o.pixel_row  = out_res.row;
  assign pix_o.pixel_col  = out_res.col;
  assign pix_o.red        = out_rgb[23:16];
  assign pix_o.green      = out_rgb[15:8];
  assign pix_o.blue       = out_rgb[7:0];
  assign pix_o.last_pixel = out_res.last;

endmodule

// ===== sv/bmpd_parse.sv =====
module bmpd_parse #(
  parameter int unsigned DIM_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        file_byte_i,
  input  logic              start_of_file_i,
  output logic              res_valid_o,
  output bmpd_pkg::res_t    res_o,
  output bmpd_pkg::pal_req_t pal_o
);
  import bmpd_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [31:0]            pos_q, pos_d;
  logic [31:0]            shift_q, shift_d;
  logic [31:0]            off_q, off_d;
  logic [34:0]            pend_q, pend_d;
  logic [DIM_BITS-1:0]    wm1_q, wm1_d, hm1_q, hm1_d;
  logic                   wzero_q, wzero_d, hzero_q, hzero_d;
  logic [DIM_BITS-1:0]    row_q, row_d, col_q, col_d;
  logic [1:0]             pad_q, pad_d;
  logic [PAL_CNT_W-1:0]   palc_q, palc_d;
  logic [7:0]             blu_q, blu_d, grn_q, grn_d;

  phase_e                 ph;
  logic [31:0]            pos, pos_inc, shift_new, count;
  logic                   last_col, last_row;
  logic [1:0]             pad_w;
  logic [DIM_BITS-1:0]    dim_new;

  always_comb begin
    ph        = start_of_file_i ? PH_HEADER : phase_q;
    pos       = start_of_file_i ? '0 : pos_q;
    shift_new = {file_byte_i, (start_of_file_i ? 24'd0 : shift_q[31:8])};
    pos_inc   = pos + 32'd1;
    dim_new   = shift_new[DIM_BITS-1:0];
    count     = (shift_new == '0) ? DEFAULT_COUNT : shift_new;
    last_col  = (col_q == wm1_q);
    last_row  = (row_q == hm1_q);
    // Padding per row is (4 - w mod 4) mod 4, i.e. the complement of (w-1) mod 4.
    pad_w     = ~wm1_q[1:0];

    phase_d = phase_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    off_d   = off_q;
    pend_d  = pend_q;
    wm1_d   = wm1_q;
    hm1_d   = hm1_q;
    wzero_d = wzero_q;
    hzero_d = hzero_q;
    row_d   = row_q;
    col_d   = col_q;
    pad_d   = pad_q;
    palc_d  = palc_q;
    blu_d   = blu_q;
    grn_d   = grn_q;

    res_valid_o    = 1'b0;
    res_o.is_error = 1'b0;
    res_o.code     = ERR_NONE;
    res_o.row      = '0;
    res_o.col      = '0;
    res_o.last     = 1'b0;

    pal_o.clear  = accept_i & start_of_file_i;
    pal_o.wr_en  = 1'b0;
    pal_o.ld_en  = 1'b0;
    pal_o.wr_idx = palc_q[PAL_CNT_W-1:2];
    pal_o.wr_rgb = {file_byte_i, grn_q, blu_q};
    pal_o.rd_en  = 1'b0;
    pal_o.rd_idx = file_byte_i[PAL_IDX_W-1:0];

    if (accept_i) begin
      phase_d = ph;
      unique case (ph)
        PH_HEADER: begin
          shift_d = shift_new;
          pos_d   = pos_inc;
          if (pos == POS_OFFSET_END) begin
            off_d = shift_new;
          end else if (pos == POS_WIDTH_END) begin
            if (shift_new[31:DIM_BITS] != '0) begin
              res_valid_o = 1'b1; res_o.is_error = 1'b1; res_o.code = ERR_DIM;
              phase_d = PH_ERROR;
            end else begin
              wm1_d   = dim_new - DIM_BITS'(1);
              wzero_d = (dim_new == '0);
            end
          end else if (pos == POS_HEIGHT_END) begin
            if (shift_new[31:DIM_BITS] != '0) begin
              res_valid_o = 1'b1; res_o.is_error = 1'b1; res_o.code = ERR_DIM;
              phase_d = PH_ERROR;
            end else begin
              hm1_d   = dim_new - DIM_BITS'(1);
              hzero_d = (dim_new == '0);
            end
          end else if (pos == POS_PLANES_END) begin
            if (shift_new[31:16] != REQ_PLANES) begin
              res_valid_o = 1'b1; res_o.is_error = 1'b1; res_o.code = ERR_PLANES;
              phase_d = PH_ERROR;
            end
          end else if (pos == POS_DEPTH_END) begin
            if (shift_new[31:16] != REQ_BPP) begin
              res_valid_o = 1'b1; res_o.is_error = 1'b1; res_o.code = ERR_DEPTH;
              phase_d = PH_ERROR;
            end
          end else if (pos == POS_COMP_END) begin
            if (shift_new != '0) begin
              res_valid_o = 1'b1; res_o.is_error = 1'b1; res_o.code = ERR_COMP;
              phase_d = PH_ERROR;
            end
          end else if (pos == POS_COUNT_END) begin
            pend_d = HDR_BYTES + {1'b0, count, 2'b00};
          end else if (pos == POS_HDR_END) begin
            if (pend_q > {3'b000, off_q}) begin
              res_valid_o = 1'b1; res_o.is_error = 1'b1; res_o.code = ERR_OFFSET;
              phase_d = PH_ERROR;
            end else begin
              phase_d = PH_PALETTE;
              palc_d  = '0;
            end
          end
        end
        PH_PALETTE: begin
          // Entries arrive as blue, green, red, reserved; the whole color is
          // written with the red byte and the entry is marked on the last byte.
          case (palc_q[1:0])
            2'd0:    blu_d = file_byte_i;
            2'd1:    grn_d = file_byte_i;
            2'd2:    pal_o.wr_en = 1'b1;
            default: pal_o.ld_en = 1'b1;
          endcase
          palc_d = palc_q + PAL_CNT_W'(1);
          pos_d  = pos_inc;
          if (pos_inc == pend_q[31:0]) begin
            if (pos_inc == off_q) begin
              row_d = '0; col_d = '0; pad_d = '0;
              phase_d = (wzero_q || hzero_q) ? PH_DONE : PH_PIXELS;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          pos_d = pos_inc;
          if (pos_inc == off_q) begin
            row_d = '0; col_d = '0; pad_d = '0;
            phase_d = (wzero_q || hzero_q) ? PH_DONE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          res_valid_o = 1'b1;
          pal_o.rd_en = 1'b1;
          res_o.row   = COORD_W'(hm1_q - row_q);
          res_o.col   = COORD_W'(col_q);
          res_o.last  = last_col & last_row;
          if (!last_col) begin
            col_d = col_q + DIM_BITS'(1);
          end else if (last_row) begin
            phase_d = PH_DONE;
          end else if (pad_w != 2'd0) begin
            pad_d   = pad_w;
            phase_d = PH_PAD;
          end else begin
            row_d = row_q + DIM_BITS'(1);
            col_d = '0;
          end
        end
        PH_PAD: begin
          pad_d = pad_q - 2'd1;
          if (pad_q == 2'd1) begin
            row_d   = row_q + DIM_BITS'(1);
            col_d   = '0;
            phase_d = PH_PIXELS;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pos_q   <= '0;
      shift_q <= '0;
      off_q   <= '0;
      pend_q  <= '0;
      wm1_q   <= '0;
      hm1_q   <= '0;
      wzero_q <= 1'b1;
      hzero_q <= 1'b1;
      row_q   <= '0;
      col_q   <= '0;
      pad_q   <= '0;
      palc_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      off_q   <= off_d;
      pend_q  <= pend_d;
      wm1_q   <= wm1_d;
      hm1_q   <= hm1_d;
      wzero_q <= wzero_d;
      hzero_q <= hzero_d;
      row_q   <= row_d;
      col_q   <= col_d;
      pad_q   <= pad_d;
      palc_q  <= palc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blu_q <= blu_d;
    grn_q <= grn_d;
  end

  // An error result always parks the parser until the next file starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.is_error) |=> (phase_q == PH_ERROR))
    else $error("error result without entering the error phase");

  // While emitting pixels the column never runs past the last column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PIXELS) |-> (col_q <= wm1_q))
    else $error("pixel column beyond image width");

endmodule

// ===== sv/bmpd_pal.sv =====
module bmpd_pal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmpd_pkg::pal_req_t req_i,
  output logic [23:0]        rdata_o,
  output logic               loaded_o
);
  import bmpd_pkg::*;

  logic [23:0]          pal_mem_q [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] loaded_q;
  logic [23:0]          rdata_q;
  logic                 ld_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      pal_mem_q[req_i.wr_idx] <= req_i.wr_rgb;
    end
    if (req_i.rd_en) begin
      rdata_q <= pal_mem_q[req_i.rd_idx];
      ld_rd_q <= loaded_q[req_i.rd_idx];
    end
  end

  // Loaded flags: cleared at once when a new file starts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
    end else if (req_i.clear) begin
      loaded_q <= '0;
    end else if (req_i.ld_en) begin
      loaded_q[req_i.wr_idx] <= 1'b1;
    end
  end

  assign rdata_o  = rdata_q;
  assign loaded_o = ld_rd_q;

  // Palette loading and pixel lookup belong to different phases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((req_i.wr_en || req_i.ld_en) && req_i.rd_en))
    else $error("palette write and pixel read in the same cycle");

  // A file restart never coincides with palette traffic.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |-> !(req_i.wr_en || req_i.ld_en || req_i.rd_en))
    else $error("palette access on a restart byte");

endmodule

// ===== sv/bmpd_out.sv =====
module bmpd_out (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           res_valid_i,
  input  bmpd_pkg::res_t res_i,
  input  logic [23:0]    rdata_i,
  input  logic           loaded_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output bmpd_pkg::res_t out_res_o,
  output logic [23:0]    out_rgb_o
);
  import bmpd_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  res_t        s1_res_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_res_q;
  logic [23:0] out_rgb_q, rgb;
  logic        s1_load, s1_adv;

  assign s1_load    = accept_i & res_valid_i;
  assign s1_adv     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | ~out_valid_q | out_ready_i;
  assign rgb        = (!s1_res_q.is_error && loaded_i) ? rdata_i : 24'd0;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_res_q <= res_i;
    end
    if (s1_adv) begin
      out_res_q <= s1_res_q;
      out_rgb_q <= rgb;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_rgb_o   = out_rgb_q;

  // With both stages full and the sink stalled, no byte may be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("byte accepted while both result stages are full");

  // A new result never lands on a held lookup stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |-> (!s1_valid_q || s1_adv))
    else $error("lookup stage overwritten");

endmodule
